[hdl/average_linkage_clustering_macros.svh]
// Assertion macros for the average-linkage clustering engine.
// No dependencies; included by the modules that check their own logic.
`ifndef AVERAGE_LINKAGE_CLUSTERING_MACROS_SVH
`define AVERAGE_LINKAGE_CLUSTERING_MACROS_SVH

// Same-cycle implication, held off during reset
`define ALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define ALC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/alc_pkg.sv]
// Shared types and constants of the average-linkage clustering engine.
// No dependencies; imported by every module of the block.
package alc_pkg;

  localparam int DEF_MAX_CLUSTERS = 64;
  localparam int CFG_W   = 7;
  localparam int VAL_W   = 32;
  localparam int LBL_W   = 8;
  localparam int PTR_W   = 12;
  localparam int PTR_MAX = 4095;
  localparam int PROD_W  = 64;
  localparam int DEN_W   = 33;

  // Input word kinds, carried in tuser
  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_DIST   = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

  // Memory selected by a read or write command
  typedef enum logic [1:0] {
    MS_DIST,
    MS_WGT,
    MS_LBL
  } msel_t;

  // Source of the two address registers
  typedef enum logic [2:0] {
    AS_PAIR_SWAP,
    AS_PAIR_AVG,
    AS_NODE_IJ,
    AS_NODE_JL,
    AS_NODE_IL
  } asrc_t;

  // Source of memory write data
  typedef enum logic [2:0] {
    WS_RDATA,
    WS_TMPA,
    WS_AVG,
    WS_WSUM,
    WS_MERGE
  } wsrc_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_LBL_ADDR,
    S_LBL_RA,
    S_LBL_RB,
    S_LBL_CB,
    S_OUT,
    S_MRG,
    S_SD_ADDR,
    S_SD_RA,
    S_SD_RB,
    S_SD_WA,
    S_SD_WB,
    S_NW_RA,
    S_NW_RB,
    S_NW_WA,
    S_NW_WB,
    S_NL_RA,
    S_NL_RB,
    S_NL_WA,
    S_NL_WB,
    S_AW_RA,
    S_AW_RB,
    S_AW_CB,
    S_AV_ADDR,
    S_AV_RA,
    S_AV_RB,
    S_AV_CB,
    S_AV_MUL,
    S_AV_DIV,
    S_AV_WAIT,
    S_AV_WR,
    S_WSUM
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_en;
    logic  run_init;
    logic  scan_clr;
    logic  scan_rd;
    logic  x_clr;
    logic  x_inc;
    logic  addr_ld;
    asrc_t asrc;
    msel_t msel;
    logic  rd_a;
    logic  rd_b;
    logic  cap_a;
    logic  cap_b;
    logic  cap_w;
    logic  wr_a;
    logic  wr_b;
    wsrc_t wsrc;
    logic  mul_ld;
    logic  div_start;
    logic  out_load;
    logic  step_next;
    logic  ptr_clr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_small;
    logic scan_end;
    logic x_done;
    logic x_eq_bi;
    logic x_eq_bj;
    logic div_done;
    logic last_one;
    logic out_busy;
  } sts_t;

endpackage

[hdl/average_linkage_clustering.sv]
// Top level of the average-linkage (UPGMA) clustering engine.
// Depends on alc_pkg, alc_ctrl and alc_datapath.
//
//  port group   dir  word contents (low bit first)
//  in_*         in   tuser: kind[1:0]; tdata: value[31:0]
//  out_*        out  tdata: left_label[7:0], right_label[15:8], merge_distance[47:16];
//                    tlast: last
//  cfg_*        in   num_clusters[6:0], written when cfg_wr_en is high
//
// Load words are taken while the engine is idle. Each merge of a run word with n
// clusters does a minimum scan over the single distance read port, fetches the
// labels, emits and marks the merge, swaps the distance pairs, swaps the weights
// and labels, reads the weights, skips or averages each row entry through the
// bit-serial divider, and writes the weight sum. No input is taken during a run.
// A result waits in the output register; the run stalls only when the next
// result is ready while the previous one is still held. Reset is synchronous,
// active low; it clears control state and label valid bits only.
module average_linkage_clustering
  import alc_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,   // num_clusters
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_tuser,      // kind
  input  logic [VAL_W-1:0] in_tdata,      // value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,     // left_label, right_label, merge_distance
  output logic             out_tlast      // last
);

  cmd_t cmd;
  sts_t sts;

  alc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  alc_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

[hdl/alc_divider.sv]
// Restoring divider, one quotient bit per cycle, for the weighted average.
// Depends on alc_pkg for the operand widths.
module alc_divider
  import alc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [VAL_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(PROD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0]  dvs_r, dvs_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_sub;
  logic              fits;

  // One shift-subtract step
  always_comb begin
    trial     = {rem_r, quo_r[PROD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[VAL_W-1:0];

endmodule

[hdl/alc_ctrl.sv]
// Sequencer of the clustering engine: loads, scan, swap and averaging loops.
// Depends on alc_pkg; drives alc_datapath through cmd_t and reads sts_t.
module alc_ctrl
  import alc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_tuser,
  input  sts_t       sts,
  output cmd_t       cmd
);

`include "average_linkage_clustering_macros.svh"

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (kind_t'(in_tuser) == KIND_RUN) && !sts.n_small) state_nxt = S_SCAN;
      end
      S_SCAN:     if (sts.scan_end) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_LBL_ADDR;
      S_LBL_ADDR: state_nxt = S_LBL_RA;
      S_LBL_RA:   state_nxt = S_LBL_RB;
      S_LBL_RB:   state_nxt = S_LBL_CB;
      S_LBL_CB:   state_nxt = S_OUT;
      S_OUT:      if (!sts.out_busy) state_nxt = S_MRG;
      S_MRG:      state_nxt = S_SD_ADDR;
      S_SD_ADDR: begin
        if (sts.x_done) state_nxt = S_NW_RA;
        else if (!sts.x_eq_bj) state_nxt = S_SD_RA;
      end
      S_SD_RA:    state_nxt = S_SD_RB;
      S_SD_RB:    state_nxt = S_SD_WA;
      S_SD_WA:    state_nxt = S_SD_WB;
      S_SD_WB:    state_nxt = S_SD_ADDR;
      S_NW_RA:    state_nxt = S_NW_RB;
      S_NW_RB:    state_nxt = S_NW_WA;
      S_NW_WA:    state_nxt = S_NW_WB;
      S_NW_WB:    state_nxt = S_NL_RA;
      S_NL_RA:    state_nxt = S_NL_RB;
      S_NL_RB:    state_nxt = S_NL_WA;
      S_NL_WA:    state_nxt = S_NL_WB;
      S_NL_WB:    state_nxt = S_AW_RA;
      S_AW_RA:    state_nxt = S_AW_RB;
      S_AW_RB:    state_nxt = S_AW_CB;
      S_AW_CB:    state_nxt = S_AV_ADDR;
      S_AV_ADDR: begin
        if (sts.x_done) state_nxt = S_WSUM;
        else if (!sts.x_eq_bi) state_nxt = S_AV_RA;
      end
      S_AV_RA:    state_nxt = S_AV_RB;
      S_AV_RB:    state_nxt = S_AV_CB;
      S_AV_CB:    state_nxt = S_AV_MUL;
      S_AV_MUL:   state_nxt = S_AV_DIV;
      S_AV_DIV:   state_nxt = S_AV_WAIT;
      S_AV_WAIT:  if (sts.div_done) state_nxt = S_AV_WR;
      S_AV_WR:    state_nxt = S_AV_ADDR;
      S_WSUM:     state_nxt = sts.last_one ? S_IDLE : S_SCAN;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd      = '0;
    cmd.asrc = AS_NODE_IJ;
    cmd.msel = MS_DIST;
    cmd.wsrc = WS_RDATA;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(in_tuser))
            KIND_WEIGHT, KIND_DIST: cmd.load_en = 1'b1;
            KIND_RUN: begin
              cmd.run_init = 1'b1;
              cmd.scan_clr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: cmd.scan_rd = 1'b1;
      S_LBL_ADDR: begin
        cmd.addr_ld = 1'b1;
        cmd.asrc    = AS_NODE_IJ;
      end
      S_LBL_RA: begin
        cmd.rd_a = 1'b1;
        cmd.msel = MS_LBL;
      end
      S_LBL_RB: begin
        cmd.rd_b  = 1'b1;
        cmd.msel  = MS_LBL;
        cmd.cap_a = 1'b1;
      end
      S_LBL_CB: cmd.cap_b = 1'b1;
      S_OUT:    cmd.out_load = !sts.out_busy;
      S_MRG: begin
        cmd.wr_a  = 1'b1;
        cmd.msel  = MS_LBL;
        cmd.wsrc  = WS_MERGE;
        cmd.x_clr = 1'b1;
      end
      S_SD_ADDR: begin
        if (sts.x_done) begin
          cmd.addr_ld = 1'b1;
          cmd.asrc    = AS_NODE_JL;
        end else if (sts.x_eq_bj) begin
          cmd.x_inc = 1'b1;
        end else begin
          cmd.addr_ld = 1'b1;
          cmd.asrc    = AS_PAIR_SWAP;
        end
      end
      S_SD_RA: cmd.rd_a = 1'b1;
      S_SD_RB: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
      end
      S_SD_WA: cmd.wr_a = 1'b1;
      S_SD_WB: begin
        cmd.wr_b  = 1'b1;
        cmd.wsrc  = WS_TMPA;
        cmd.x_inc = 1'b1;
      end
      S_NW_RA: begin
        cmd.rd_a = 1'b1;
        cmd.msel = MS_WGT;
      end
      S_NW_RB: begin
        cmd.rd_b  = 1'b1;
        cmd.msel  = MS_WGT;
        cmd.cap_a = 1'b1;
      end
      S_NW_WA: begin
        cmd.wr_a = 1'b1;
        cmd.msel = MS_WGT;
      end
      S_NW_WB: begin
        cmd.wr_b = 1'b1;
        cmd.msel = MS_WGT;
        cmd.wsrc = WS_TMPA;
      end
      S_NL_RA: begin
        cmd.rd_a = 1'b1;
        cmd.msel = MS_LBL;
      end
      S_NL_RB: begin
        cmd.rd_b  = 1'b1;
        cmd.msel  = MS_LBL;
        cmd.cap_a = 1'b1;
      end
      S_NL_WA: begin
        cmd.wr_a = 1'b1;
        cmd.msel = MS_LBL;
      end
      S_NL_WB: begin
        cmd.wr_b    = 1'b1;
        cmd.msel    = MS_LBL;
        cmd.wsrc    = WS_TMPA;
        cmd.addr_ld = 1'b1;
        cmd.asrc    = AS_NODE_IL;
      end
      S_AW_RA: begin
        cmd.rd_a = 1'b1;
        cmd.msel = MS_WGT;
      end
      S_AW_RB: begin
        cmd.rd_b  = 1'b1;
        cmd.msel  = MS_WGT;
        cmd.cap_a = 1'b1;
      end
      S_AW_CB: begin
        cmd.cap_w = 1'b1;
        cmd.x_clr = 1'b1;
      end
      S_AV_ADDR: begin
        if (sts.x_done) begin
          cmd.addr_ld = 1'b1;
          cmd.asrc    = AS_NODE_IL;
        end else if (sts.x_eq_bi) begin
          cmd.x_inc = 1'b1;
        end else begin
          cmd.addr_ld = 1'b1;
          cmd.asrc    = AS_PAIR_AVG;
        end
      end
      S_AV_RA: cmd.rd_a = 1'b1;
      S_AV_RB: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
      end
      S_AV_CB:  cmd.cap_b = 1'b1;
      S_AV_MUL: cmd.mul_ld = 1'b1;
      S_AV_DIV: cmd.div_start = 1'b1;
      S_AV_WR: begin
        cmd.wr_a  = 1'b1;
        cmd.wsrc  = WS_AVG;
        cmd.x_inc = 1'b1;
      end
      S_WSUM: begin
        cmd.wr_a      = 1'b1;
        cmd.msel      = MS_WGT;
        cmd.wsrc      = WS_WSUM;
        cmd.step_next = 1'b1;
        cmd.ptr_clr   = sts.last_one;
        cmd.scan_clr  = !sts.last_one;
      end
      default: ;
    endcase
  end

  `ALC_ASSERT_IMP(a_div_done_wait, clk, rst_n, sts.div_done, state_r == S_AV_WAIT, "divider finished outside the wait state")
  `ALC_ASSERT_NXT(a_final_to_idle, clk, rst_n, (state_r == S_WSUM) && sts.last_one, state_r == S_IDLE, "final merge did not end the run")
  `ALC_ASSERT_IMP(a_scan_end_seen, clk, rst_n, state_r == S_SCAN_END, $past(sts.scan_end), "scan left before its last read")

endmodule

[hdl/alc_datapath.sv]
// Datapath of the clustering engine: distance, weight and label memories,
// scan and loop counters, weighted-average arithmetic and result register.
// Depends on alc_pkg and alc_divider; steered by alc_ctrl through cmd_t.
module alc_datapath
  import alc_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic [1:0]       in_tuser,
  input  logic [VAL_W-1:0] in_tdata,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tlast
);

`include "average_linkage_clustering_macros.svh"

  localparam int DIST_DEPTH = (MAX_CLUSTERS * (MAX_CLUSTERS - 1)) / 2;
  localparam int IW   = $clog2(MAX_CLUSTERS);
  localparam int NW   = $clog2(MAX_CLUSTERS + 1);
  localparam int DA_W = $clog2(DIST_DEPTH + 1);
  localparam int AW   = (DA_W > IW) ? DA_W : IW;

  // Packed triangle address of pair (i,j), i<j
  function automatic logic [DA_W-1:0] tri_addr(input logic [IW-1:0] i, input logic [IW-1:0] j);
    logic [2*IW-1:0] p;
    p = (2*IW)'(j) * (2*IW)'(j - 1'b1);
    return DA_W'((p >> 1) + (2*IW)'(i));
  endfunction

  // Memories
  logic [VAL_W-1:0] dmem [DIST_DEPTH];
  logic [VAL_W-1:0] wmem [MAX_CLUSTERS];
  logic [LBL_W-1:0] lmem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] lab_v_r;

  logic [CFG_W-1:0] num_r;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0]    last_r, step_r, x_r;
  logic [IW-1:0]    bi_r, bj_r, si_r, sj_r, pi_r, pj_r;
  logic [VAL_W-1:0] bd_r;
  logic [DA_W-1:0]  k_r;
  logic             first_r, pend_r;
  logic [AW-1:0]    addr_a_r, addr_b_r;
  logic [VAL_W-1:0] tmpa_r, tmpb_r, wa_r, wb_r, base_r;
  logic [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0] den_r;
  msel_t            rsel_r;
  logic [VAL_W-1:0] d_rdata_r, w_rdata_r;
  logic [LBL_W-1:0] l_rdata_r;
  logic             l_valid_r;
  logic [IW-1:0]    l_ridx_r;
  logic             out_valid_r;
  logic [LBL_W-1:0] out_left_r, out_right_r;
  logic [VAL_W-1:0] out_dist_r;
  logic             out_last_r;

  logic [NW-1:0]    n_c;
  logic [PTR_W-1:0] pdiff;
  logic             ld_w_we, ld_d_we;
  logic [IW-1:0]    piv, lo_idx, hi_idx;
  logic [DA_W-1:0]  pair_a, pair_b;
  logic [AW-1:0]    addr_a_nxt, addr_b_nxt;
  logic [VAL_W-1:0] rd_data, wdata, quotient, avg_val;
  logic [LBL_W-1:0] lbl_rd, lbl_merge;
  logic [DEN_W-1:0] wsum_full;
  logic [VAL_W-1:0] wsum;
  logic             div_done;
  logic             den0, ge;
  logic [VAL_W-1:0] mul_op, diff;
  logic             mem_wr;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             d_we, w_we, l_we;
  logic [DA_W-1:0]  d_waddr, d_raddr;
  logic [IW-1:0]    w_waddr, w_raddr, l_waddr, l_raddr;
  logic [VAL_W-1:0] d_wdata, w_wdata;

  // Clamped cluster count
  always_comb begin
    if (32'(num_r) > 32'(MAX_CLUSTERS)) n_c = NW'(MAX_CLUSTERS);
    else n_c = NW'(num_r);
  end

  // Load addressing
  always_comb begin
    pdiff   = ptr_r - PTR_W'(num_r);
    ld_w_we = cmd.load_en && (kind_t'(in_tuser) == KIND_WEIGHT)
              && (32'(ptr_r) < 32'(MAX_CLUSTERS));
    ld_d_we = cmd.load_en && (kind_t'(in_tuser) == KIND_DIST)
              && (ptr_r >= PTR_W'(num_r)) && (32'(pdiff) < 32'(DIST_DEPTH));
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) ptr_nxt = '0;
    else if (cmd.load_en && (ptr_r != PTR_W'(PTR_MAX))
             && ((kind_t'(in_tuser) == KIND_WEIGHT) || (kind_t'(in_tuser) == KIND_DIST)))
      ptr_nxt = ptr_r + 1'b1;
  end

  // Pair and node addresses
  always_comb begin
    piv    = (cmd.asrc == AS_PAIR_AVG) ? bi_r : bj_r;
    lo_idx = (x_r < piv) ? x_r : piv;
    hi_idx = (x_r < piv) ? piv : x_r;
    pair_a = tri_addr(lo_idx, hi_idx);
    pair_b = tri_addr(x_r, last_r);
    case (cmd.asrc)
      AS_PAIR_SWAP, AS_PAIR_AVG: begin
        addr_a_nxt = AW'(pair_a);
        addr_b_nxt = AW'(pair_b);
      end
      AS_NODE_JL: begin
        addr_a_nxt = AW'(bj_r);
        addr_b_nxt = AW'(last_r);
      end
      AS_NODE_IL: begin
        addr_a_nxt = AW'(bi_r);
        addr_b_nxt = AW'(last_r);
      end
      default: begin
        addr_a_nxt = AW'(bi_r);
        addr_b_nxt = AW'(bj_r);
      end
    endcase
  end

  // Read data of the last command read
  always_comb begin
    lbl_rd = l_valid_r ? l_rdata_r : LBL_W'(l_ridx_r) + 1'b1;
    case (rsel_r)
      MS_DIST: rd_data = d_rdata_r;
      MS_WGT:  rd_data = w_rdata_r;
      MS_LBL:  rd_data = VAL_W'(lbl_rd);
      default: rd_data = '0;
    endcase
  end

  // Write data sources
  always_comb begin
    lbl_merge = LBL_W'(0) - LBL_W'(step_r) - 1'b1;
    wsum_full = {1'b0, wa_r} + {1'b0, wb_r};
    wsum      = wsum_full[DEN_W-1] ? '1 : wsum_full[VAL_W-1:0];
    avg_val   = base_r + quotient;
    case (cmd.wsrc)
      WS_RDATA: wdata = rd_data;
      WS_TMPA:  wdata = tmpa_r;
      WS_AVG:   wdata = avg_val;
      WS_WSUM:  wdata = wsum;
      WS_MERGE: wdata = VAL_W'(lbl_merge);
      default:  wdata = '0;
    endcase
  end

  // Memory port steering
  always_comb begin
    mem_wr  = cmd.wr_a || cmd.wr_b;
    wr_addr = cmd.wr_b ? addr_b_r : addr_a_r;
    rd_addr = cmd.rd_b ? addr_b_r : addr_a_r;
    d_we    = ld_d_we || (mem_wr && (cmd.msel == MS_DIST));
    d_waddr = ld_d_we ? DA_W'(pdiff) : wr_addr[DA_W-1:0];
    d_wdata = ld_d_we ? in_tdata : wdata;
    d_raddr = cmd.scan_rd ? k_r : rd_addr[DA_W-1:0];
    w_we    = ld_w_we || (mem_wr && (cmd.msel == MS_WGT));
    w_waddr = ld_w_we ? IW'(ptr_r) : wr_addr[IW-1:0];
    w_wdata = ld_w_we ? in_tdata : wdata;
    w_raddr = rd_addr[IW-1:0];
    l_we    = mem_wr && (cmd.msel == MS_LBL);
    l_waddr = wr_addr[IW-1:0];
    l_raddr = rd_addr[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    d_rdata_r <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_waddr] <= wdata[LBL_W-1:0];
    l_rdata_r <= lmem[l_raddr];
    l_valid_r <= lab_v_r[l_raddr];
    l_ridx_r  <= l_raddr;
  end

  // Label valid bits: unwritten labels read as index plus one
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.run_init) begin
      lab_v_r <= '0;
    end else if (l_we) begin
      lab_v_r[l_waddr] <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) num_r <= cfg_wr_data;
      ptr_r  <= ptr_nxt;
      pend_r <= cmd.scan_rd;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Step and loop counters
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      last_r <= IW'(n_c - 1'b1);
      step_r <= '0;
    end else if (cmd.step_next) begin
      last_r <= last_r - 1'b1;
      step_r <= step_r + 1'b1;
    end
    if (cmd.x_clr) x_r <= '0;
    else if (cmd.x_inc) x_r <= x_r + 1'b1;
  end

  // Minimum scan in packed order; first entry seeds the search
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      k_r     <= '0;
      si_r    <= '0;
      sj_r    <= IW'(1);
      first_r <= 1'b1;
    end else if (cmd.scan_rd) begin
      k_r  <= k_r + 1'b1;
      pi_r <= si_r;
      pj_r <= sj_r;
      if (IW'(si_r + 1'b1) == sj_r) begin
        si_r <= '0;
        sj_r <= sj_r + 1'b1;
      end else begin
        si_r <= si_r + 1'b1;
      end
    end
    if (pend_r && (first_r || (d_rdata_r < bd_r))) begin
      bd_r    <= d_rdata_r;
      bi_r    <= pi_r;
      bj_r    <= pj_r;
      first_r <= 1'b0;
    end
  end

  // Operand captures and multiply stage
  always_comb begin
    den0   = (wa_r == '0) && (wb_r == '0);
    ge     = (tmpa_r >= tmpb_r);
    diff   = ge ? (tmpa_r - tmpb_r) : (tmpb_r - tmpa_r);
    mul_op = den0 ? VAL_W'(1) : (ge ? wa_r : wb_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_ld) begin
      addr_a_r <= addr_a_nxt;
      addr_b_r <= addr_b_nxt;
    end
    if (cmd.rd_a || cmd.rd_b) rsel_r <= cmd.msel;
    if (cmd.cap_a) tmpa_r <= rd_data;
    if (cmd.cap_b) tmpb_r <= rd_data;
    if (cmd.cap_w) begin
      wa_r <= tmpa_r;
      wb_r <= rd_data;
    end
    if (cmd.mul_ld) begin
      prod_r <= PROD_W'(mul_op) * PROD_W'(diff);
      base_r <= ge ? tmpb_r : tmpa_r;
      den_r  <= den0 ? DEN_W'(2) : wsum_full;
    end
  end

  alc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_r  <= tmpa_r[LBL_W-1:0];
      out_right_r <= tmpb_r[LBL_W-1:0];
      out_dist_r  <= bd_r;
      out_last_r  <= (last_r == IW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dist_r, out_right_r, out_left_r};
  assign out_tlast  = out_last_r;

  // Status
  always_comb begin
    sts          = '0;
    sts.n_small  = (n_c < NW'(2));
    sts.scan_end = (si_r == IW'(last_r - 1'b1)) && (sj_r == last_r);
    sts.x_done   = (x_r >= last_r);
    sts.x_eq_bi  = (x_r == bi_r);
    sts.x_eq_bj  = (x_r == bj_r);
    sts.div_done = div_done;
    sts.last_one = (last_r == IW'(1));
    sts.out_busy = out_valid_r && !out_tready;
  end

  `ALC_ASSERT_IMP(a_scan_order, clk, rst_n, pend_r, pj_r > pi_r, "scan pair out of order")
  `ALC_ASSERT_IMP(a_scan_bound, clk, rst_n, cmd.scan_rd, sj_r <= last_r, "scan past last live node")
  `ALC_ASSERT_IMP(a_avg_pair, clk, rst_n, cmd.wr_a && (cmd.wsrc == WS_AVG), addr_a_r != addr_b_r, "average row entry aliases its partner")

endmodule
